/* rtl/cfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

   // Characters that steer the parser.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   // Field counter saturates at its all-ones value.
   localparam int unsigned FIELD_COUNT_W = 9;
   localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_MAX = '1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_INDEX  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_CAPACITY = 2'd1;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [CSR_DATA_W-1:0] OUT_CAPACITY_RESET = 9'd256;

   // Result kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_char;
      logic       found;
      logic [7:0] length;
   } result_type;

endpackage

`default_nettype wire

/* rtl/cfe_line_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfe_line_parser #(
   parameter int unsigned MAX_CAPACITY = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire logic [7:0]                         char_byte,
   input  wire logic [7:0]                         field_index,
   input  wire logic [cfe_pkg::CSR_DATA_W-1:0]     out_capacity,
   output logic                                    has_result,
   output cfe_pkg::result_type                     result
);
   import cfe_pkg::*;

   localparam int unsigned CNT_W = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
   localparam int unsigned CAP_W = $clog2(MAX_CAPACITY + 1);
   localparam int unsigned EW    = ((CAP_W > CSR_DATA_W) ? CAP_W : CSR_DATA_W) + 1;
   localparam logic [EW-1:0] MAX_CAP_EXT = EW'(MAX_CAPACITY);

   logic                     in_quotes_ff, in_quotes_in;
   logic                     quote_pending_ff, quote_pending_in;
   logic                     skip_to_eol_ff, skip_to_eol_in;
   logic [FIELD_COUNT_W-1:0] field_count_ff, field_count_in;
   logic [CNT_W-1:0]         emitted_count_ff, emitted_count_in;

   logic [EW-1:0] cap_ext;
   logic [EW-1:0] eff_cap;
   logic [EW-1:0] emitted_ext;
   logic          is_term;
   logic          selected;
   logic          can_put;
   logic          put_req;
   logic [7:0]    put_char;
   logic          unquoted;

   // Capacity of zero behaves as one, anything above the buffer size as the buffer size.
   assign cap_ext     = EW'(out_capacity);
   assign eff_cap     = (cap_ext == '0) ? EW'(1) :
                        ((cap_ext > MAX_CAP_EXT) ? MAX_CAP_EXT : cap_ext);
   assign emitted_ext = EW'(emitted_count_ff);

   assign is_term  = (char_byte == CH_NUL) || (char_byte == CH_LF) || (char_byte == CH_CR);
   assign selected = (field_count_ff == FIELD_COUNT_W'(field_index));
   assign can_put  = selected && ((emitted_ext + EW'(1)) < eff_cap);

   always_comb begin
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      skip_to_eol_in   = skip_to_eol_ff;
      field_count_in   = field_count_ff;
      emitted_count_in = emitted_count_ff;
      has_result       = 1'b0;
      result           = '0;
      put_req          = 1'b0;
      put_char         = char_byte;
      unquoted         = 1'b0;

      if (skip_to_eol_ff) begin
         if (is_term) begin
            in_quotes_in     = 1'b0;
            quote_pending_in = 1'b0;
            skip_to_eol_in   = 1'b0;
            field_count_in   = '0;
            emitted_count_in = '0;
         end
      end else if (is_term) begin
         has_result       = 1'b1;
         result.kind      = KIND_DONE;
         result.found     = selected;
         result.length    = emitted_ext[7:0];
         in_quotes_in     = 1'b0;
         quote_pending_in = 1'b0;
         field_count_in   = '0;
         emitted_count_in = '0;
      end else begin
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (char_byte == CH_QUOTE) begin
               put_req  = 1'b1;
               put_char = CH_QUOTE;
            end else begin
               in_quotes_in = 1'b0;
               unquoted     = 1'b1;
            end
         end else if (in_quotes_ff) begin
            if (char_byte == CH_QUOTE) begin
               quote_pending_in = 1'b1;
            end else begin
               put_req = 1'b1;
            end
         end else begin
            unquoted = 1'b1;
         end

         if (unquoted) begin
            if (char_byte == CH_QUOTE) begin
               in_quotes_in = 1'b1;
            end else if (char_byte == CH_COMMA) begin
               if (selected) begin
                  skip_to_eol_in = 1'b1;
                  has_result     = 1'b1;
                  result.kind    = KIND_DONE;
                  result.found   = 1'b1;
                  result.length  = emitted_ext[7:0];
               end else if (field_count_ff != FIELD_COUNT_MAX) begin
                  field_count_in = field_count_ff + FIELD_COUNT_W'(1);
               end
            end else begin
               put_req = 1'b1;
            end
         end

         if (put_req && can_put) begin
            emitted_count_in = emitted_count_ff + CNT_W'(1);
            has_result       = 1'b1;
            result.kind      = KIND_CHAR;
            result.out_char  = put_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         skip_to_eol_ff   <= 1'b0;
         field_count_ff   <= '0;
         emitted_count_ff <= '0;
      end else if (step) begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         skip_to_eol_ff   <= skip_to_eol_in;
         field_count_ff   <= field_count_in;
         emitted_count_ff <= emitted_count_in;
      end
   end

   // A pending quote can only arise inside quotes.
   assert property (@(posedge clock) disable iff (reset)
      quote_pending_ff |-> in_quotes_ff)
      else $error("quote pending outside quoted mode");

   // Skipping starts only from an unquoted comma.
   assert property (@(posedge clock) disable iff (reset)
      skip_to_eol_ff |-> (!in_quotes_ff && !quote_pending_ff))
      else $error("skipping while in quoted mode");

   // The emitted count stays below the largest buffer size.
   assert property (@(posedge clock) disable iff (reset)
      emitted_ext < MAX_CAP_EXT)
      else $error("emitted count reached the buffer size");

   // Each emitted character bumps the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (step && has_result && (result.kind == KIND_CHAR))
      |=> (emitted_count_ff == $past(emitted_count_ff) + CNT_W'(1)))
      else $error("character emitted without count update");

endmodule

`default_nettype wire

/* rtl/csv_field_extractor.sv */
`timescale 1ns / 1ps
`default_nettype none

// CSV field extractor.
// Bytes of one CSV line enter on the req_ channel, one byte per request. For each
// byte the block produces at most one response on the rsp_ channel: either a
// character of the selected field (rsp_kind = 0) or a done marker (rsp_kind = 1)
// carrying whether the field existed and how many characters were passed on.
// Quotes are stripped, a doubled quote inside quotes gives one quote, and commas
// inside quotes are literal. NUL, LF or CR ends the line; after the comma that
// closes the selected field the remainder of the line is swallowed silently.
// The csr_ port sets the field number and the output capacity; write it only
// while the block is idle.
// A response is registered in the cycle after its request is accepted. Throughput
// is one request per cycle while responses are taken, and the line state is updated
// on each accepted request; the response register lets a new request in whenever
// it is empty or being drained in the same cycle. When the receiver stalls with a
// response waiting, req_ready drops until that response is taken.
// Reset clears the line state and the response register, and returns the field
// number to 0 and the capacity to 256.

module csv_field_extractor #(
   parameter int unsigned MAX_CAPACITY = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_char_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_kind,
   output logic [7:0]                             rsp_out_char,
   output logic                                   rsp_found,
   output logic [7:0]                             rsp_length,
   input  wire logic                              csr_we,
   input  wire logic [cfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cfe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cfe_pkg::*;

   logic [7:0]            field_index_ff;
   logic [CSR_DATA_W-1:0] out_capacity_ff;

   logic       accept;
   logic       has_result;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // A request is taken when the response register is free or drains this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Configuration registers; writes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff  <= '0;
         out_capacity_ff <= OUT_CAPACITY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIELD_INDEX:  field_index_ff  <= csr_wdata[7:0];
            CSR_OUT_CAPACITY: out_capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   cfe_line_parser #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .char_byte    (req_char_byte),
      .field_index  (field_index_ff),
      .out_capacity (out_capacity_ff),
      .has_result   (has_result),
      .result       (result)
   );

   // Response register: loaded on every accepted request that yields a result, emptied when taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_data_ff.kind;
   assign rsp_out_char = rsp_data_ff.out_char;
   assign rsp_found    = rsp_data_ff.found;
   assign rsp_length   = rsp_data_ff.length;

endmodule

`default_nettype wire
